// File: rtl/u8dw_pkg.sv
package u8dw_pkg;

    // Widths of the stream and of the gathered sequence value
    localparam int unsigned ByteW  = 8;
    localparam int unsigned ValueW = 24;
    localparam int unsigned TotalW = 16;
    localparam int unsigned ExtraW = 2;
    localparam int unsigned LeftW  = 2;

    typedef logic [ValueW-1:0] seq_value_t;
    typedef logic [ExtraW-1:0] extra_t;
    typedef logic [TotalW-1:0] total_t;
    typedef logic [LeftW-1:0]  left_t;

    // Continuation bytes still expected after a lead byte
    localparam left_t LEFT_NONE  = 2'd0;
    localparam left_t LEFT_ONE   = 2'd1;
    localparam left_t LEFT_TWO   = 2'd2;
    localparam left_t LEFT_THREE = 2'd3;

    // Extra display spaces
    localparam extra_t EXTRA_ONE   = 2'd1;
    localparam extra_t EXTRA_TWO   = 2'd2;
    localparam extra_t EXTRA_THREE = 2'd3;

    localparam total_t TOTAL_MAX = 16'hFFFF;

    // Range table bounds, big-endian sequence values
    localparam seq_value_t R1_LO  = 24'h00C2A0;
    localparam seq_value_t R1_HI  = 24'h00C3BF;
    localparam seq_value_t R2_LO  = 24'h00CDB0;
    localparam seq_value_t R2_HI  = 24'h00CFBF;
    localparam seq_value_t R3_LO  = 24'hE38299;
    localparam seq_value_t R3_HI  = 24'hE3829C;
    localparam seq_value_t R4_LO  = 24'hE2BA80;
    localparam seq_value_t R4_HI  = 24'hEA938F;
    localparam seq_value_t R5_LO  = 24'hEAB080;
    localparam seq_value_t R5_HI  = 24'hED9EAF;
    localparam seq_value_t R6_LO  = 24'hEDA080;
    localparam seq_value_t R6_HI  = 24'hEFB7BF;
    localparam seq_value_t R7_LO  = 24'hEFB8B0;
    localparam seq_value_t R7_HI  = 24'hEFB9AF;
    localparam seq_value_t R8_LO  = 24'hEFBC80;
    localparam seq_value_t R8_HI  = 24'hEFBFAF;
    localparam seq_value_t R8W_LO = 24'hEFBDA5;
    localparam seq_value_t R8W_HI = 24'hEFBF9C;

endpackage

// File: rtl/utf8_extra_display_width_unit.sv
// UTF-8 extra display width counter. Bytes of a string enter one per transaction on the
// s_ channel; the byte with s_end_of_string high closes the string and produces one
// transaction on the m_ channel carrying the summed extra display spaces of all completed
// multibyte sequences, saturated at 65535. The sequence state and running total are
// updated at acceptance, the range lookup and saturating add sit between those registers,
// and the total is held in an output register, so a byte is accepted every cycle unless
// that output register is full and m_ready is low. A result appears on m_ in the cycle
// after its last byte is accepted. Invalid lead bytes count as plain bytes, continuation
// bytes are not checked, and a sequence cut short by the end of the string adds nothing.
module utf8_extra_display_width_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_end_of_string,
    output logic                   m_valid,
    input  logic                   m_ready,
    output u8dw_pkg::total_t       m_extra_total
);
    import u8dw_pkg::*;

    seq_value_t seq_value_reg, seq_value_next;
    logic       seq_four_reg, seq_four_next;
    left_t      bytes_left_reg, bytes_left_next;
    total_t     running_total_reg, running_total_next;
    logic       m_valid_reg, m_valid_next;
    total_t     m_extra_total_reg, m_extra_total_next;

    logic          s_accept;
    seq_value_t    shifted_value;
    extra_t        seq_extra;
    logic [TotalW:0] total_sum;
    total_t        total_sat;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_extra_total = m_extra_total_reg;

    // Append the incoming byte to the open sequence
    assign shifted_value = {seq_value_reg[ValueW-ByteW-1:0], s_data_byte};

    u8dw_extra u_extra (
        .seq_value (shifted_value),
        .seq_four  (seq_four_reg),
        .extra     (seq_extra)
    );

    // Saturating add of the completed sequence's extra spaces
    assign total_sum = {1'b0, running_total_reg} + {{(TotalW+1-ExtraW){1'b0}}, seq_extra};
    assign total_sat = total_sum[TotalW] ? TOTAL_MAX : total_sum[TotalW-1:0];

    // Advance sequence state and total for each accepted transaction
    always_comb begin
        seq_value_next     = seq_value_reg;
        seq_four_next      = seq_four_reg;
        bytes_left_next    = bytes_left_reg;
        running_total_next = running_total_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_extra_total_next = m_extra_total_reg;

        if (s_accept) begin
            if (bytes_left_reg != LEFT_NONE) begin
                bytes_left_next = bytes_left_reg - LEFT_ONE;
                if (bytes_left_reg == LEFT_ONE) begin
                    running_total_next = total_sat;
                    seq_value_next     = '0;
                    seq_four_next      = 1'b0;
                end else begin
                    seq_value_next = shifted_value;
                end
            end else begin
                seq_value_next = {{(ValueW-ByteW){1'b0}}, s_data_byte};
                seq_four_next  = 1'b0;
                if (s_data_byte[7:5] == 3'b110) begin
                    bytes_left_next = LEFT_ONE;
                end else if (s_data_byte[7:4] == 4'b1110) begin
                    bytes_left_next = LEFT_TWO;
                end else if (s_data_byte[7:3] == 5'b11110) begin
                    bytes_left_next = LEFT_THREE;
                    seq_four_next   = 1'b1;
                end else begin
                    // Single byte or invalid lead: nothing to track
                    seq_value_next = seq_value_reg;
                end
            end

            // Emit the total on the last byte and clear all state
            if (s_end_of_string) begin
                m_valid_next       = 1'b1;
                m_extra_total_next = running_total_next;
                running_total_next = '0;
                seq_value_next     = '0;
                seq_four_next      = 1'b0;
                bytes_left_next    = LEFT_NONE;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_value_reg     <= '0;
            seq_four_reg      <= 1'b0;
            bytes_left_reg    <= LEFT_NONE;
            running_total_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            seq_value_reg     <= seq_value_next;
            seq_four_reg      <= seq_four_next;
            bytes_left_reg    <= bytes_left_next;
            running_total_reg <= running_total_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge aclk) begin
        m_extra_total_reg <= m_extra_total_next;
    end

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid_reg)
        else $error("input stalled while output register empty");

    a_last_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_end_of_string) |=>
            (m_valid_reg && bytes_left_reg == LEFT_NONE && running_total_reg == '0))
        else $error("state not cleared after last byte");

    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_end_of_string) |=>
            (running_total_reg >= $past(running_total_reg)))
        else $error("running total decreased within a string");

    a_four_only_open: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_four_reg |-> (bytes_left_reg != LEFT_NONE))
        else $error("four-byte flag set with no open sequence");
`endif

endmodule

// File: rtl/u8dw_extra.sv
module u8dw_extra (
    input  u8dw_pkg::seq_value_t seq_value,
    input  logic                 seq_four,
    output u8dw_pkg::extra_t     extra
);
    import u8dw_pkg::*;

    // Look up the extra spaces of a completed sequence, first matching range wins
    always_comb begin
        if (seq_four) begin
            extra = EXTRA_TWO;
        end else if (seq_value >= R1_LO && seq_value <= R1_HI) begin
            extra = EXTRA_ONE;
        end else if (seq_value >= R2_LO && seq_value <= R2_HI) begin
            extra = EXTRA_ONE;
        end else if (seq_value >= R3_LO && seq_value <= R3_HI) begin
            extra = EXTRA_THREE;
        end else if (seq_value >= R4_LO && seq_value <= R4_HI) begin
            extra = EXTRA_ONE;
        end else if (seq_value >= R5_LO && seq_value <= R5_HI) begin
            extra = EXTRA_ONE;
        end else if (seq_value >= R6_LO && seq_value <= R6_HI) begin
            extra = EXTRA_ONE;
        end else if (seq_value >= R7_LO && seq_value <= R7_HI) begin
            extra = EXTRA_ONE;
        end else if (seq_value >= R8_LO && seq_value <= R8_HI) begin
            if (seq_value >= R8W_LO && seq_value <= R8W_HI) begin
                extra = EXTRA_TWO;
            end else begin
                extra = EXTRA_ONE;
            end
        end else begin
            extra = EXTRA_TWO;
        end
    end

endmodule
